[src/dgsa_pkg.sv]
// Shared constants, codes and types of the dense grid slot allocator.
package dgsa_pkg;

	localparam int MAX_PAGES = 4;
	localparam int MAX_COLS  = 16;
	localparam int MAX_ROWS  = 16;
	localparam int TAG_BITS  = 16;

	localparam int PAGE_W  = $clog2(MAX_PAGES);
	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int CPAGE_W = $clog2(MAX_PAGES + 1);
	localparam int ADDR_W  = PAGE_W + ROW_W + COL_W;
	localparam int DEPTH   = MAX_PAGES * MAX_ROWS * MAX_COLS;
	localparam int LIVE_W  = $clog2(DEPTH + 1);
	localparam int GEOM_W  = 5;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_LIVE = 2'd2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ACROSS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN   = 1'd1;

	typedef enum logic {
		S_IDLE,
		S_MOVE
	} state_t;

	// Commit strobes from the sequencer to the position tracker.
	typedef struct packed {
		logic alloc;
		logic free;
	} cmd_t;

	// Decisions and addresses that the position tracker offers.
	typedef struct packed {
		logic              full;
		logic              free_ok;
		logic              free_last;
		logic              opened;
		logic              released;
		logic [ADDR_W-1:0] cur_addr;
		logic [ADDR_W-1:0] last_addr;
		logic [LIVE_W-1:0] live;
	} view_t;

	// Map a written geometry value onto 1..limit.
	function automatic logic [GEOM_W-1:0] clamp_geom(input logic [GEOM_W-1:0] v,
			input logic [GEOM_W-1:0] limit);
		logic [GEOM_W-1:0] r;
		if (v == '0) begin
			r = GEOM_W'(1);
		end else if (v > limit) begin
			r = limit;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[src/dgsa_tag_ram.sv]
// Tag store: one write port, one read port, registered read data.
module dgsa_tag_ram (
	input  logic                               clk,
	input  logic                               we,
	input  logic [dgsa_pkg::ADDR_W-1:0]        waddr,
	input  logic [dgsa_pkg::TAG_BITS-1:0]      wdata,
	input  logic                               re,
	input  logic [dgsa_pkg::ADDR_W-1:0]        raddr,
	output logic [dgsa_pkg::TAG_BITS-1:0]      rdata
);

	logic [dgsa_pkg::TAG_BITS-1:0] mem_q [dgsa_pkg::DEPTH];
	logic [dgsa_pkg::TAG_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/dgsa_track.sv]
// Geometry registers, live count and the cursor / last-cell positions.
module dgsa_track (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dgsa_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [dgsa_pkg::GEOM_W-1:0]         cfg_val,
	input  dgsa_pkg::cmd_t                      cmd,
	input  logic [dgsa_pkg::PAGE_W-1:0]         free_page,
	input  logic [dgsa_pkg::COL_W-1:0]          free_col,
	input  logic [dgsa_pkg::ROW_W-1:0]          free_row,
	output dgsa_pkg::view_t                     view
);

	logic [dgsa_pkg::GEOM_W-1:0]  across_q, down_q;
	logic [dgsa_pkg::LIVE_W-1:0]  live_q;
	logic [dgsa_pkg::CPAGE_W-1:0] cur_page_q;
	logic [dgsa_pkg::COL_W-1:0]   cur_col_q;
	logic [dgsa_pkg::ROW_W-1:0]   cur_row_q;
	logic [dgsa_pkg::PAGE_W-1:0]  last_page_q;
	logic [dgsa_pkg::COL_W-1:0]   last_col_q;
	logic [dgsa_pkg::ROW_W-1:0]   last_row_q;

	logic [dgsa_pkg::COL_W-1:0]   col_max;
	logic [dgsa_pkg::ROW_W-1:0]   row_max;
	logic [dgsa_pkg::CPAGE_W-1:0] nxt_page;
	logic [dgsa_pkg::COL_W-1:0]   nxt_col;
	logic [dgsa_pkg::ROW_W-1:0]   nxt_row;
	logic [dgsa_pkg::PAGE_W-1:0]  prv_page;
	logic [dgsa_pkg::COL_W-1:0]   prv_col;
	logic [dgsa_pkg::ROW_W-1:0]   prv_row;
	logic                         in_geom;
	logic                         below_cur;

	assign col_max = dgsa_pkg::COL_W'(across_q - dgsa_pkg::GEOM_W'(1));
	assign row_max = dgsa_pkg::ROW_W'(down_q - dgsa_pkg::GEOM_W'(1));

	// Step the cursor forward in page, row, column order.
	always_comb begin
		nxt_page = cur_page_q;
		nxt_row  = cur_row_q;
		nxt_col  = cur_col_q + dgsa_pkg::COL_W'(1);
		if (cur_col_q == col_max) begin
			nxt_col = '0;
			nxt_row = cur_row_q + dgsa_pkg::ROW_W'(1);
			if (cur_row_q == row_max) begin
				nxt_row  = '0;
				nxt_page = cur_page_q + dgsa_pkg::CPAGE_W'(1);
			end
		end
	end

	// Step the last cell back; an empty store parks it at zero.
	always_comb begin
		prv_page = last_page_q;
		prv_row  = last_row_q;
		prv_col  = last_col_q - dgsa_pkg::COL_W'(1);
		if (live_q == dgsa_pkg::LIVE_W'(1)) begin
			prv_page = '0;
			prv_row  = '0;
			prv_col  = '0;
		end else if (last_col_q == '0) begin
			prv_col = col_max;
			prv_row = last_row_q - dgsa_pkg::ROW_W'(1);
			if (last_row_q == '0) begin
				prv_row  = row_max;
				prv_page = last_page_q - dgsa_pkg::PAGE_W'(1);
			end
		end
	end

	assign in_geom = ({1'b0, free_col} < across_q) && ({1'b0, free_row} < down_q) &&
		(dgsa_pkg::CPAGE_W'(free_page) < dgsa_pkg::CPAGE_W'(dgsa_pkg::MAX_PAGES));
	assign below_cur = {dgsa_pkg::CPAGE_W'(free_page), free_row, free_col} <
		{cur_page_q, cur_row_q, cur_col_q};

	always_comb begin
		view.full      = (cur_page_q == dgsa_pkg::CPAGE_W'(dgsa_pkg::MAX_PAGES));
		view.free_ok   = in_geom && below_cur;
		view.free_last = ({free_page, free_row, free_col} ==
			{last_page_q, last_row_q, last_col_q});
		view.opened    = (cur_col_q == '0) && (cur_row_q == '0);
		view.released  = (last_col_q == '0) && (last_row_q == '0);
		view.cur_addr  = {cur_page_q[dgsa_pkg::PAGE_W-1:0], cur_row_q, cur_col_q};
		view.last_addr = {last_page_q, last_row_q, last_col_q};
		view.live      = live_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			across_q    <= dgsa_pkg::GEOM_W'(dgsa_pkg::MAX_COLS);
			down_q      <= dgsa_pkg::GEOM_W'(dgsa_pkg::MAX_ROWS);
			live_q      <= '0;
			cur_page_q  <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			last_page_q <= '0;
			last_col_q  <= '0;
			last_row_q  <= '0;
		end else begin
			// Geometry holds while any cell is live.
			if (cfg_we && live_q == '0) begin
				unique case (cfg_idx)
					dgsa_pkg::REG_ACROSS: across_q <= dgsa_pkg::clamp_geom(cfg_val,
						dgsa_pkg::GEOM_W'(dgsa_pkg::MAX_COLS));
					dgsa_pkg::REG_DOWN: down_q <= dgsa_pkg::clamp_geom(cfg_val,
						dgsa_pkg::GEOM_W'(dgsa_pkg::MAX_ROWS));
					default: ;
				endcase
			end
			if (cmd.alloc) begin
				live_q      <= live_q + dgsa_pkg::LIVE_W'(1);
				last_page_q <= cur_page_q[dgsa_pkg::PAGE_W-1:0];
				last_col_q  <= cur_col_q;
				last_row_q  <= cur_row_q;
				cur_page_q  <= nxt_page;
				cur_col_q   <= nxt_col;
				cur_row_q   <= nxt_row;
			end else if (cmd.free) begin
				live_q      <= live_q - dgsa_pkg::LIVE_W'(1);
				cur_page_q  <= dgsa_pkg::CPAGE_W'(last_page_q);
				cur_col_q   <= last_col_q;
				cur_row_q   <= last_row_q;
				last_page_q <= prv_page;
				last_col_q  <= prv_col;
				last_row_q  <= prv_row;
			end
		end
	end

endmodule

[src/dense_grid_slot_allocator.sv]
// Dense grid slot allocator: stream sequencer, result register and tag store.
//
// Usage: items enter on the s_ channel. s_tuser selects alloc (0) or free (1).
// An alloc writes its tag into the next free cell in row-major order and
// returns that cell's page, column and row; a free moves the tag of the last
// live cell into the freed cell and returns the moved tag. One result item
// leaves on the m_ channel for every input item, with the status in m_tuser.
// The cfg_ channel writes the grid size (index 0 columns, index 1 rows); a
// write is taken every cycle and ignored while any cell is live.
// Timing: the result of an alloc, an error, or a free of the last live cell is
// valid the cycle after accept. A free that moves a tag goes through S_MOVE:
// the tag store read of the last cell is registered, and the write into the
// freed cell follows in S_MOVE. Sustained rate is one item per cycle for allocs
// while m_tready is high; no new item is taken while a moving free is in S_MOVE.
// The result register parts the two sides: a new item is taken in the same
// cycle that the previous result is taken. While m_tready is low a valid result
// holds and s_tready drops. Reset empties the store at once (no clearing
// pass) and sets the grid to 16 by 16; tag entries are undefined until written.
module dense_grid_slot_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,  // tag, cell_page, cell_col, cell_row
	input  logic                              s_tuser,  // mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [39:0]                       m_tdata,  // out_page, out_col, out_row,
	                                                    // page_opened, page_released, moved,
	                                                    // moved_tag, live_cells
	output logic [dgsa_pkg::STAT_W-1:0]       m_tuser,  // status
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dgsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dgsa_pkg::GEOM_W-1:0]       cfg_data
);

	dgsa_pkg::state_t state_q, state_d;
	dgsa_pkg::cmd_t   cmd;
	dgsa_pkg::view_t  view;

	logic [dgsa_pkg::TAG_BITS-1:0] in_tag;
	logic [dgsa_pkg::PAGE_W-1:0]   in_page;
	logic [dgsa_pkg::COL_W-1:0]    in_col;
	logic [dgsa_pkg::ROW_W-1:0]    in_row;
	logic                          accept;
	logic                          move_go;

	logic                          ram_we, ram_re;
	logic [dgsa_pkg::ADDR_W-1:0]   ram_waddr;
	logic [dgsa_pkg::TAG_BITS-1:0] ram_wdata, ram_rdata;

	logic                          load;
	logic [dgsa_pkg::STAT_W-1:0]   res_status;
	logic [dgsa_pkg::PAGE_W-1:0]   res_page;
	logic [dgsa_pkg::COL_W-1:0]    res_col;
	logic [dgsa_pkg::ROW_W-1:0]    res_row;
	logic                          res_opened, res_released, res_moved;
	logic [dgsa_pkg::LIVE_W-1:0]   res_live;

	logic                          out_valid_q;
	logic [dgsa_pkg::STAT_W-1:0]   status_q;
	logic [dgsa_pkg::PAGE_W-1:0]   page_q;
	logic [dgsa_pkg::COL_W-1:0]    col_q;
	logic [dgsa_pkg::ROW_W-1:0]    row_q;
	logic                          opened_q, released_q, moved_q;
	logic [dgsa_pkg::TAG_BITS-1:0] moved_tag_q;
	logic [dgsa_pkg::LIVE_W-1:0]   live_q;
	logic [dgsa_pkg::ADDR_W-1:0]   free_addr_q;

	assign in_tag  = s_tdata[15:0];
	assign in_page = s_tdata[17:16];
	assign in_col  = s_tdata[21:18];
	assign in_row  = s_tdata[25:22];

	assign s_tready  = (state_q == dgsa_pkg::S_IDLE) && (!out_valid_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign move_go   = accept && (s_tuser == dgsa_pkg::MODE_FREE) && view.free_ok &&
		!view.free_last;

	dgsa_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_val   (cfg_data),
		.cmd       (cmd),
		.free_page (in_page),
		.free_col  (in_col),
		.free_row  (in_row),
		.view      (view)
	);

	dgsa_tag_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (view.last_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dgsa_pkg::S_IDLE: if (move_go) state_d = dgsa_pkg::S_MOVE;
			dgsa_pkg::S_MOVE: state_d = dgsa_pkg::S_IDLE;
			default: state_d = dgsa_pkg::S_IDLE;
		endcase
	end

	// Decode the accepted item into tracker strobes, store access and result.
	always_comb begin
		cmd          = '0;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		ram_waddr    = view.cur_addr;
		ram_wdata    = in_tag;
		load         = 1'b0;
		res_status   = dgsa_pkg::ST_OK;
		res_page     = '0;
		res_col      = '0;
		res_row      = '0;
		res_opened   = 1'b0;
		res_released = 1'b0;
		res_moved    = 1'b0;
		res_live     = view.live;
		unique case (state_q)
			dgsa_pkg::S_IDLE: begin
				if (accept) begin
					load = 1'b1;
					if (s_tuser == dgsa_pkg::MODE_ALLOC) begin
						if (view.full) begin
							res_status = dgsa_pkg::ST_FULL;
						end else begin
							cmd.alloc  = 1'b1;
							ram_we     = 1'b1;
							{res_page, res_row, res_col} = view.cur_addr;
							res_opened = view.opened;
							res_live   = view.live + dgsa_pkg::LIVE_W'(1);
						end
					end else begin
						res_page = in_page;
						res_col  = in_col;
						res_row  = in_row;
						if (!view.free_ok) begin
							res_status = dgsa_pkg::ST_NOT_LIVE;
						end else begin
							cmd.free     = 1'b1;
							ram_re       = !view.free_last;
							res_moved    = !view.free_last;
							res_released = view.released;
							res_live     = view.live - dgsa_pkg::LIVE_W'(1);
						end
					end
				end
			end
			dgsa_pkg::S_MOVE: begin
				// Write the tag of the old last cell into the freed cell.
				ram_we    = 1'b1;
				ram_waddr = free_addr_q;
				ram_wdata = ram_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dgsa_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dgsa_pkg::S_MOVE) begin
				out_valid_q <= 1'b1;
			end else if (load) begin
				out_valid_q <= !move_go;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q    <= res_status;
			page_q      <= res_page;
			col_q       <= res_col;
			row_q       <= res_row;
			opened_q    <= res_opened;
			released_q  <= res_released;
			moved_q     <= res_moved;
			moved_tag_q <= '0;
			live_q      <= res_live;
			free_addr_q <= {in_page, in_row, in_col};
		end else if (state_q == dgsa_pkg::S_MOVE) begin
			moved_tag_q <= ram_rdata;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {live_q, moved_tag_q, moved_q, released_q, opened_q,
		row_q, col_q, page_q};

endmodule

[bench/tb_dense_grid_slot_allocator.sv]
// Self-checking bench for the dense grid slot allocator: predicted alloc and free results.
module tb_dense_grid_slot_allocator;

	localparam int LIMIT  = 400000;
	localparam int NGRIDS = 7;

	typedef struct packed {
		logic                          mode;
		logic [dgsa_pkg::TAG_BITS-1:0] tag;
		logic [dgsa_pkg::PAGE_W-1:0]   page;
		logic [dgsa_pkg::COL_W-1:0]    col;
		logic [dgsa_pkg::ROW_W-1:0]    row;
	} req_t;

	typedef struct packed {
		logic [dgsa_pkg::STAT_W-1:0]   status;
		logic [dgsa_pkg::PAGE_W-1:0]   page;
		logic [dgsa_pkg::COL_W-1:0]    col;
		logic [dgsa_pkg::ROW_W-1:0]    row;
		logic                          opened;
		logic                          released;
		logic                          moved;
		logic [dgsa_pkg::TAG_BITS-1:0] moved_tag;
		logic [dgsa_pkg::LIVE_W-1:0]   live;
	} grant_t;

	typedef struct {
		int page;
		int col;
		int row;
	} spot_t;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [31:0]                    s_tdata   = '0;
	logic                           s_tuser   = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [39:0]                    m_tdata;
	logic [dgsa_pkg::STAT_W-1:0]    m_tuser;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [dgsa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [dgsa_pkg::GEOM_W-1:0]    cfg_data  = '0;

	dense_grid_slot_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Request stream and expected grants
	req_t   pending_reqs[$];
	grant_t due_grants[$];
	int     items_sent   = 0;
	int     results_seen = 0;
	int     errors       = 0;
	int     cycles       = 0;
	logic   took         = 1'b0;
	logic   cfg_took     = 1'b0;

	// Predicted allocator state
	logic [dgsa_pkg::GEOM_W-1:0]   geo_across = dgsa_pkg::GEOM_W'(16);
	logic [dgsa_pkg::GEOM_W-1:0]   geo_down   = dgsa_pkg::GEOM_W'(16);
	int                            held_cells = 0;
	logic [dgsa_pkg::TAG_BITS-1:0] tag_store[0:dgsa_pkg::DEPTH-1];

	// What the predicted stream went through
	int n_placed = 0, n_full = 0, n_moves = 0, n_tail_frees = 0, n_not_live = 0;
	int n_opened = 0, n_released = 0;

	// Generator's view of the live count and geometry
	int plan_a    = 16;
	int plan_d    = 16;
	int plan_live = 0;

	function automatic int clamp_dim(int v, int lim);
		if (v == 0) return 1;
		return (v > lim) ? lim : v;
	endfunction

	function automatic spot_t spot_of(int pos, int across, int cap);
		spot_t s;
		s.page = pos / cap;
		s.col  = (pos % cap) % across;
		s.row  = (pos % cap) / across;
		return s;
	endfunction

	function automatic logic [dgsa_pkg::ADDR_W-1:0] cell_addr(int page, int col, int row);
		return dgsa_pkg::ADDR_W'((page * dgsa_pkg::MAX_ROWS + row) * dgsa_pkg::MAX_COLS + col);
	endfunction

	function automatic grant_t apply_request(req_t q);
		grant_t g;
		int a, d, cap, pos;
		spot_t s, tail;
		a   = clamp_dim(int'(geo_across), dgsa_pkg::MAX_COLS);
		d   = clamp_dim(int'(geo_down), dgsa_pkg::MAX_ROWS);
		cap = a * d;
		g   = '0;
		if (q.mode == dgsa_pkg::MODE_ALLOC) begin
			if (held_cells >= dgsa_pkg::MAX_PAGES * cap) begin
				g.status = dgsa_pkg::ST_FULL;
				n_full++;
			end else begin
				s = spot_of(held_cells, a, cap);
				g.page   = dgsa_pkg::PAGE_W'(s.page);
				g.col    = dgsa_pkg::COL_W'(s.col);
				g.row    = dgsa_pkg::ROW_W'(s.row);
				g.opened = (held_cells % cap == 0);
				tag_store[cell_addr(s.page, s.col, s.row)] = q.tag;
				held_cells++;
				n_placed++;
				if (g.opened) n_opened++;
			end
		end else begin
			g.page = q.page;
			g.col  = q.col;
			g.row  = q.row;
			pos    = int'(q.page) * cap + int'(q.row) * a + int'(q.col);
			if (int'(q.col) >= a || int'(q.row) >= d || pos >= held_cells) begin
				g.status = dgsa_pkg::ST_NOT_LIVE;
				n_not_live++;
			end else begin
				// fill the hole with the tail cell's tag to keep the store dense
				if (pos != held_cells - 1) begin
					tail = spot_of(held_cells - 1, a, cap);
					g.moved_tag = tag_store[cell_addr(tail.page, tail.col, tail.row)];
					tag_store[cell_addr(q.page, q.col, q.row)] = g.moved_tag;
					g.moved = 1'b1;
					n_moves++;
				end else begin
					n_tail_frees++;
				end
				held_cells--;
				g.released = (held_cells % cap == 0);
				if (g.released) n_released++;
			end
		end
		g.live = dgsa_pkg::LIVE_W'(held_cells);
		return g;
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
			results_seen, what, got, want);
		errors++;
	endtask

	task automatic check_grant(grant_t got, grant_t want);
		if (got.status !== want.status)
			flag_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.page !== want.page)
			flag_mismatch("out_page", 32'(got.page), 32'(want.page));
		if (got.col !== want.col)
			flag_mismatch("out_col", 32'(got.col), 32'(want.col));
		if (got.row !== want.row)
			flag_mismatch("out_row", 32'(got.row), 32'(want.row));
		if (got.opened !== want.opened)
			flag_mismatch("page_opened", 32'(got.opened), 32'(want.opened));
		if (got.released !== want.released)
			flag_mismatch("page_released", 32'(got.released), 32'(want.released));
		if (got.moved !== want.moved)
			flag_mismatch("moved", 32'(got.moved), 32'(want.moved));
		if (got.moved_tag !== want.moved_tag)
			flag_mismatch("moved_tag", 32'(got.moved_tag), 32'(want.moved_tag));
		if (got.live !== want.live)
			flag_mismatch("live_cells", 32'(got.live), 32'(want.live));
	endtask

	// Monitor: check result items, then predict the item accepted at this edge
	always @(posedge clk) begin : watch
		grant_t got;
		req_t   req;
		took     <= s_tvalid && s_tready;
		cfg_took <= cfg_valid && cfg_ready;
		if (arst_n) begin
			cycles++;
			if (m_tvalid && m_tready) begin
				got.status    = m_tuser;
				got.page      = m_tdata[1:0];
				got.col       = m_tdata[5:2];
				got.row       = m_tdata[9:6];
				got.opened    = m_tdata[10];
				got.released  = m_tdata[11];
				got.moved     = m_tdata[12];
				got.moved_tag = m_tdata[28:13];
				got.live      = m_tdata[39:29];
				if (due_grants.size() == 0) begin
					$display("unexpected result item %0d: 0x%0h status %0d",
						results_seen, m_tdata, m_tuser);
					errors++;
				end else begin
					check_grant(got, due_grants.pop_front());
				end
				results_seen++;
			end
			// geometry writes only land while the store is empty
			if (cfg_valid && cfg_ready && held_cells == 0) begin
				if (cfg_index == dgsa_pkg::REG_ACROSS) geo_across = cfg_data;
				else if (cfg_index == dgsa_pkg::REG_DOWN) geo_down = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				req.mode = s_tuser;
				req.tag  = s_tdata[15:0];
				req.page = s_tdata[17:16];
				req.col  = s_tdata[21:18];
				req.row  = s_tdata[25:22];
				due_grants.push_back(apply_request(req));
			end
			if (cycles > LIMIT) begin
				$display("timeout after %0d cycles, %0d of %0d results seen",
					cycles, results_seen, items_sent);
				$display("tb_dense_grid_slot_allocator failed");
				$finish;
			end
		end
	end

	// Driver: sender bursts and gaps, receiver stall pattern
	req_t nxt;
	int   gap_left   = 0;
	int   burst_left = 0;
	int   stall_kind = 0;
	int   stall_run  = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || took) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					nxt = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= nxt.mode;
					s_tdata  <= {6'b0, nxt.row, nxt.col, nxt.page, nxt.tag};
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(30, 0);
						gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (stall_run == 0) begin
				stall_kind = $urandom_range(2, 0);
				stall_run  = $urandom_range(40, 4);
			end else begin
				stall_run--;
			end
			case (stall_kind)
				0: begin
					m_tready <= 1'b1;
				end
				1: begin
					m_tready <= 1'($urandom_range(1, 0));
				end
				default: begin
					m_tready <= (stall_run % 4 == 0);
				end
			endcase
		end
	end

	task automatic queue_req(req_t r);
		int pos;
		pending_reqs.push_back(r);
		items_sent++;
		if (r.mode == dgsa_pkg::MODE_ALLOC) begin
			if (plan_live < dgsa_pkg::MAX_PAGES * plan_a * plan_d) plan_live++;
		end else begin
			pos = int'(r.page) * plan_a * plan_d + int'(r.row) * plan_a + int'(r.col);
			if (int'(r.col) < plan_a && int'(r.row) < plan_d && pos < plan_live) plan_live--;
		end
	endtask

	task automatic add_alloc(logic [dgsa_pkg::TAG_BITS-1:0] tag);
		req_t r;
		r      = req_t'($urandom);
		r.mode = dgsa_pkg::MODE_ALLOC;
		r.tag  = tag;
		queue_req(r);
	endtask

	task automatic add_free(int page, int col, int row);
		req_t r;
		r.mode = dgsa_pkg::MODE_FREE;
		r.tag  = dgsa_pkg::TAG_BITS'($urandom);
		r.page = dgsa_pkg::PAGE_W'(page);
		r.col  = dgsa_pkg::COL_W'(col);
		r.row  = dgsa_pkg::ROW_W'(row);
		queue_req(r);
	endtask

	task automatic add_free_at(int pos);
		spot_t s;
		s = spot_of(pos, plan_a, plan_a * plan_d);
		add_free(s.page, s.col, s.row);
	endtask

	// Hold the sender until every queued item has its result
	task automatic drain_results();
		while (results_seen < items_sent) @(negedge clk);
	endtask

	task automatic write_grid_reg(logic [dgsa_pkg::CFG_IDX_W-1:0] idx,
			logic [dgsa_pkg::GEOM_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_took);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_grid(int across, int down);
		write_grid_reg(dgsa_pkg::REG_ACROSS, dgsa_pkg::GEOM_W'(across));
		write_grid_reg(dgsa_pkg::REG_DOWN, dgsa_pkg::GEOM_W'(down));
		if (plan_live == 0) begin
			plan_a = clamp_dim(across, dgsa_pkg::MAX_COLS);
			plan_d = clamp_dim(down, dgsa_pkg::MAX_ROWS);
		end
	endtask

	initial begin : stimulus
		int grid_a[NGRIDS];
		int grid_d[NGRIDS];
		int ph, k, r, n;
		logic fill;
		req_t raw;
		grid_a = '{1, 0, 31, 3, 2, 16, 5};
		grid_d = '{1, 31, 0, 5, 2, 16, 7};
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// reset geometry, then a write that must be ignored while a cell is live
		add_alloc(16'h0000);
		drain_results();
		set_grid(3, 3);
		add_free(0, 0, 0);
		drain_results();

		// one cell per page: fill, overflow, move, out-of-geometry and dead frees
		set_grid(1, 1);
		add_alloc(16'hFFFF);
		add_alloc(16'h0001);
		add_alloc(16'h8000);
		add_alloc(16'h1234);
		add_alloc(16'hBEEF);
		add_free(1, 0, 0);
		add_free(0, 1, 0);
		add_free(3, 0, 0);
		add_free(3, 15, 15);
		add_free(2, 0, 0);
		add_free(0, 0, 0);
		add_free(0, 0, 0);
		add_free(0, 0, 0);
		drain_results();

		n = 155;
		for (ph = 0; ph < NGRIDS; ph++) begin
			set_grid(grid_a[ph], grid_d[ph]);
			for (k = 0; k < n; k++) begin
				fill = (k < n / 2);
				r = $urandom_range(99, 0);
				if (r < (fill ? 60 : 30)) begin
					add_alloc(dgsa_pkg::TAG_BITS'($urandom));
				end else if (r < (fill ? 70 : 42)) begin
					raw      = req_t'($urandom);
					raw.mode = dgsa_pkg::MODE_FREE;
					queue_req(raw);
				end else if (plan_live == 0) begin
					add_alloc(dgsa_pkg::TAG_BITS'($urandom));
				end else if ($urandom_range(3, 0) == 0) begin
					add_free_at(plan_live - 1);
				end else begin
					add_free_at($urandom_range(plan_live - 1, 0));
				end
				if (ph == 3 && k == n / 2) drain_results();
			end
			// empty the store so the next geometry takes
			while (plan_live > 0) add_free_at($urandom_range(plan_live - 1, 0));
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (due_grants.size() != 0) begin
			$display("%0d expected results never arrived", due_grants.size());
			errors++;
		end
		$display("covered %0d items: %0d cells placed, %0d store-full, %0d frees with a move,",
			items_sent, n_placed, n_full, n_moves);
		$display("  %0d tail frees, %0d dead-cell frees, %0d pages opened, %0d released",
			n_tail_frees, n_not_live, n_opened, n_released);
		$display("  %0d errors", errors);
		if (errors == 0) begin
			$display("tb_dense_grid_slot_allocator passed");
		end else begin
			$display("tb_dense_grid_slot_allocator failed");
		end
		$finish;
	end

endmodule

[dense_grid_slot_allocator.f]
src/dgsa_pkg.sv
src/dgsa_tag_ram.sv
src/dgsa_track.sv
src/dense_grid_slot_allocator.sv
bench/tb_dense_grid_slot_allocator.sv
